// File: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on the clock edge, off while reset is active
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// property sampled on the clock edge, reset included
`define ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: hdl/sacl_pkg.sv
// shared types and constants of the set associative lru lookup unit
// no dependencies
`default_nettype none

package sacl_pkg;

    localparam int TAG_W = 28;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;

    localparam logic [1:0] CFG_OFFSET = 2'd0;
    localparam logic [1:0] CFG_INDEX  = 2'd1;
    localparam logic [1:0] CFG_WAYS   = 2'd2;

    localparam logic [2:0] OFF_MIN     = 3'd4;
    localparam logic [2:0] OFF_RESET   = 3'd4;
    localparam logic [3:0] INDEX_RESET = 4'd12;
    localparam logic [3:0] WAYS_RESET  = 4'd1;

    typedef enum logic [1:0] {
        OUT_HIT    = 2'd0,
        OUT_FILL   = 2'd1,
        OUT_EVICT  = 2'd2,
        OUT_IGNORE = 2'd3
    } t_outcome;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

// File: hdl/sacl_ctrl.sv
// sequencer of the lookup unit: clear sweep, accept, lookup and write-back
// depends on sacl_pkg
`default_nettype none

module sacl_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire sacl_pkg::t_status i_status,
    output sacl_pkg::t_cmd         o_cmd
);
    import sacl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.commit = !i_status.out_busy;
                if (!i_status.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/sacl_datapath.sv
// config registers, address split, set memories, lru update, counters, result register
// depends on sacl_pkg
`default_nettype none

module sacl_datapath #(
    parameter int MAX_SETS = 4096,
    parameter int MAX_WAYS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sacl_pkg::t_cmd     i_cmd,
    output sacl_pkg::t_status       o_status,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [3:0]         i_cfg_data,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [31:0]        i_address,
    input  wire logic               i_out_ready,
    output logic                    o_out_valid,
    output sacl_pkg::t_outcome      o_outcome,
    output logic [2:0]              o_way_used,
    output logic [31:0]             o_hit_total,
    output logic [31:0]             o_miss_total,
    output logic [31:0]             o_evict_total
);
    import sacl_pkg::*;

    localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
    localparam int SETW   = (IB_MAX > 0) ? IB_MAX : 1;
    localparam int NSETS  = 1 << IB_MAX;
    localparam int NW     = MAX_WAYS;
    localparam int WW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AW     = WW;

    logic [2:0] r_off;
    logic [3:0] r_ib;
    logic [3:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= OFF_RESET;
            r_ib   <= INDEX_RESET;
            r_ways <= WAYS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OFFSET: r_off  <= i_cfg_data[2:0];
                CFG_INDEX:  r_ib   <= i_cfg_data;
                CFG_WAYS:   r_ways <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective geometry
    logic [2:0]       off_eff;
    logic [4:0]       ib_eff;
    logic [4:0]       nways;
    logic [31:0]      addr_sh;
    logic [31:0]      tag_sh;
    logic [SETW-1:0]  set_mask;
    logic [SETW-1:0]  set_in;
    logic [TAG_W-1:0] tag_in;

    always_comb begin
        off_eff = (r_off < OFF_MIN) ? OFF_MIN : r_off;
        ib_eff  = (5'(r_ib) > 5'(IB_MAX)) ? 5'(IB_MAX) : 5'(r_ib);
        if (r_ways == 4'd0) begin
            nways = 5'd1;
        end else if (5'(r_ways) > 5'(MAX_WAYS)) begin
            nways = 5'(MAX_WAYS);
        end else begin
            nways = 5'(r_ways);
        end
        for (int j = 0; j < SETW; j++) begin
            set_mask[j] = (5'(j) < ib_eff);
        end
        addr_sh = i_address >> off_eff;
        tag_sh  = i_address >> (6'(off_eff) + 6'(ib_eff));
        set_in  = addr_sh[SETW-1:0] & set_mask;
        tag_in  = tag_sh[TAG_W-1:0];
    end

    // request registers
    logic [SETW-1:0]  r_set;
    logic [TAG_W-1:0] r_tag;
    logic             r_ign;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_set <= set_in;
            r_tag <= tag_in;
            r_ign <= !(i_req_type inside {REQ_READ, REQ_WRITE});
        end
    end

    // clear sweep counter
    logic [SETW-1:0] r_clr_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // set memories, one row per set
    logic [NW-1:0]       mem_valid [NSETS];
    logic [NW*AW-1:0]    mem_age   [NSETS];
    logic [NW*TAG_W-1:0] mem_tag   [NSETS];

    logic [NW-1:0]       r_rd_valid;
    logic [NW*AW-1:0]    r_rd_age;
    logic [NW*TAG_W-1:0] r_rd_tag;

    logic                wr_en;
    logic                wr_tag_en;
    logic [SETW-1:0]     wr_addr;
    logic [NW-1:0]       wr_valid;
    logic [NW*AW-1:0]    wr_age;
    logic [NW*AW-1:0]    reset_age;

    logic [NW-1:0]       new_valid;
    logic [NW*AW-1:0]    new_age;
    logic [NW*TAG_W-1:0] new_tag;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_valid[wr_addr] <= wr_valid;
            mem_age[wr_addr]   <= wr_age;
        end
        if (wr_tag_en) begin
            mem_tag[wr_addr] <= new_tag;
        end
        if (i_cmd.accept) begin
            r_rd_valid <= mem_valid[set_in];
            r_rd_age   <= mem_age[set_in];
            r_rd_tag   <= mem_tag[set_in];
        end
    end

    // lookup and lru update
    logic [AW-1:0]    age    [NW];
    logic [TAG_W-1:0] rd_tag [NW];
    logic [NW-1:0]    use_w;
    logic             hit;
    logic [WW-1:0]    hit_way;
    logic [WW-1:0]    vic;
    logic [AW-1:0]    vic_age;
    logic [WW-1:0]    sel_way;
    logic [AW-1:0]    ref_age;
    logic [AW-1:0]    upd_age;
    logic             evict;
    logic [4:0]       way_ext;

    always_comb begin
        for (int i = 0; i < NW; i++) begin
            age[i]    = r_rd_age[i*AW +: AW];
            rd_tag[i] = r_rd_tag[i*TAG_W +: TAG_W];
            use_w[i]  = (5'(i) < nways);
        end

        hit     = 1'b0;
        hit_way = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (use_w[i] && r_rd_valid[i] && (rd_tag[i] == r_tag)) begin
                hit     = 1'b1;
                hit_way = WW'(i);
            end
        end

        vic     = '0;
        vic_age = age[0];
        for (int i = 1; i < NW; i++) begin
            if (use_w[i] && (age[i] > vic_age)) begin
                vic     = WW'(i);
                vic_age = age[i];
            end
        end

        sel_way = hit ? hit_way : vic;
        ref_age = hit ? age[hit_way] : vic_age;
        evict   = !hit && r_rd_valid[vic];
        way_ext = 5'(sel_way);

        for (int i = 0; i < NW; i++) begin
            upd_age = age[i];
            if (WW'(i) == sel_way) begin
                upd_age = '0;
            end else if (use_w[i] && (age[i] < ref_age)) begin
                upd_age = age[i] + 1'b1;
            end
            new_age[i*AW +: AW] = upd_age;
            new_valid[i]        = r_rd_valid[i] || (!hit && (WW'(i) == sel_way));
            if (!hit && (WW'(i) == sel_way)) begin
                new_tag[i*TAG_W +: TAG_W] = r_tag;
            end else begin
                new_tag[i*TAG_W +: TAG_W] = rd_tag[i];
            end
            reset_age[i*AW +: AW] = AW'(i);
        end

        wr_en     = i_cmd.clr_we || (i_cmd.commit && !r_ign);
        wr_tag_en = i_cmd.commit && !r_ign && !hit;
        wr_addr   = i_cmd.clr_we ? r_clr_idx : r_set;
        wr_valid  = i_cmd.clr_we ? '0 : new_valid;
        wr_age    = i_cmd.clr_we ? reset_age : new_age;
    end

    // counters and result register
    logic [31:0] r_hits;
    logic [31:0] r_misses;
    logic [31:0] r_evicts;
    logic        r_out_valid;
    t_outcome    r_out_outcome;
    logic [2:0]  r_out_way;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= '0;
            r_misses    <= '0;
            r_evicts    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (!r_ign) begin
                    if (hit) begin
                        r_hits <= r_hits + 32'd1;
                    end else begin
                        r_misses <= r_misses + 32'd1;
                    end
                    if (evict) begin
                        r_evicts <= r_evicts + 32'd1;
                    end
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_ign) begin
                r_out_outcome <= OUT_IGNORE;
                r_out_way     <= 3'd0;
            end else begin
                r_out_outcome <= hit ? OUT_HIT : (evict ? OUT_EVICT : OUT_FILL);
                r_out_way     <= way_ext[2:0];
            end
        end
    end

    assign o_status.clr_last = (r_clr_idx == SETW'(NSETS - 1));
    assign o_status.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_outcome     = r_out_outcome;
    assign o_way_used    = r_out_way;
    assign o_hit_total   = r_hits;
    assign o_miss_total  = r_misses;
    assign o_evict_total = r_evicts;

endmodule

`default_nettype wire

// File: hdl/set_assoc_cache_lru_lookup_unit.sv
// top level of the set associative tag store with true lru replacement
// depends on sacl_pkg, sacl_ctrl, sacl_datapath
//
// usage:
//   request channel i_in_valid / o_in_ready carries i_req_type and i_address.
//   result channel o_out_valid / i_out_ready carries o_outcome, o_way_used
//   and the running hit, miss and eviction totals after that transaction.
//   config port i_cfg_we / i_cfg_idx / i_cfg_data writes offset bits (0),
//   index bits (1) and ways in use (2); write only when idle.
// timing:
//   a request is taken in the idle cycle and the set row is read from memory at
//   that edge; the lookup state then does the lookup, lru update and
//   write-back and loads the result register. a new request is taken only
//   after the previous one has been written back.
// reset and stall:
//   after reset a clearing pass writes every one of the 2**floor(log2(MAX_SETS))
//   set rows (4096 by default), one row per cycle, with o_in_ready low.
//   a held result does not block acceptance; the lookup cycle waits until
//   the result register is free.
`default_nettype none

module set_assoc_cache_lru_lookup_unit #(
    parameter int MAX_SETS = 4096,
    parameter int MAX_WAYS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_address,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_outcome,
    output logic [2:0]       o_way_used,
    output logic [31:0]      o_hit_total,
    output logic [31:0]      o_miss_total,
    output logic [31:0]      o_evict_total
);
    import sacl_pkg::*;

    t_cmd     cmd;
    t_status  status;
    t_outcome outcome;

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    sacl_datapath #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_outcome     (outcome),
        .o_way_used    (o_way_used),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

    assign o_outcome = outcome;

endmodule

`default_nettype wire

// File: hdl/sacl_checker.sv
// port level checks of the lookup unit, attached by bind
// depends on sacl_pkg, assert_macros.svh, set_assoc_cache_lru_lookup_unit
`default_nettype none
`include "assert_macros.svh"

module sacl_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_outcome,
    input wire logic [2:0]  o_way_used,
    input wire logic [31:0] o_hit_total,
    input wire logic [31:0] o_miss_total,
    input wire logic [31:0] o_evict_total
);
    import sacl_pkg::*;

    `ASSERT_ANY(a_reset_quiet, i_clk, !i_rst_n |=> !o_in_ready && !o_out_valid)
    `ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_outcome)
        && $stable(o_way_used) && $stable(o_hit_total))
    `ASSERT_RST(a_ignore_way, i_clk, i_rst_n,
        o_out_valid && (o_outcome == OUT_IGNORE) |-> o_way_used == 3'd0)
    `ASSERT_RST(a_hit_step, i_clk, i_rst_n,
        $past(i_rst_n) && !$stable(o_hit_total) |-> $stable(o_miss_total)
        && (o_outcome == OUT_HIT) && (o_hit_total == $past(o_hit_total) + 32'd1))
    `ASSERT_RST(a_evict_miss, i_clk, i_rst_n,
        $past(i_rst_n) && !$stable(o_evict_total) |-> !$stable(o_miss_total)
        && (o_outcome == OUT_EVICT))

endmodule

bind set_assoc_cache_lru_lookup_unit sacl_checker u_sacl_checker (.*);

`default_nettype wire

// File: bench/lru_tag_tracker_pkg.sv
// tag store tracker for the set associative lru lookup unit bench
// holds its own copy of tags, valid bits, ages, totals and settings
// depends on sacl_pkg
`timescale 1ns / 1ps

package lru_tag_tracker_pkg;

    import sacl_pkg::*;

    localparam int MAX_SETS       = 4096;
    localparam int MAX_WAYS       = 8;
    localparam int LINES          = MAX_SETS * MAX_WAYS;
    localparam int MAX_INDEX_BITS = $clog2(MAX_SETS + 1) - 1;

    localparam logic [1:0] REQ_FETCH = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        t_outcome    outcome;
        logic [2:0]  way;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } t_lookup_result;

    class tag_store_tracker;
        bit               line_valid [LINES];
        logic [TAG_W-1:0] line_tag [LINES];
        logic [2:0]       line_age [LINES];
        logic [31:0]      hit_count;
        logic [31:0]      miss_count;
        logic [31:0]      evict_count;
        logic [2:0]       offset_reg;
        logic [3:0]       index_reg;
        logic [3:0]       ways_reg;
        t_lookup_result   expected_results [$];
        int               mismatches;
        int               checked;

        function new();
            int i;
            for (i = 0; i < LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_age[i]   = 3'(i % MAX_WAYS);
            end
            hit_count   = '0;
            miss_count  = '0;
            evict_count = '0;
            offset_reg  = OFF_RESET;
            index_reg   = INDEX_RESET;
            ways_reg    = WAYS_RESET;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [3:0] data);
            case (idx)
                CFG_OFFSET: offset_reg = data[2:0];
                CFG_INDEX:  index_reg  = data;
                CFG_WAYS:   ways_reg   = data;
                default: ;
            endcase
        endfunction

        function int unsigned eff_offset();
            return (offset_reg < OFF_MIN) ? int'(OFF_MIN) : int'(offset_reg);
        endfunction

        function int unsigned eff_index();
            return (index_reg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(index_reg);
        endfunction

        function int unsigned eff_ways();
            if (ways_reg == 0)
                return 1;
            return (ways_reg > MAX_WAYS) ? MAX_WAYS : int'(ways_reg);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // lookup, fill and lru aging for one accepted read or write; other kinds give an ignore result
        function void note_request(logic [1:0] kind, logic [31:0] addr);
            int unsigned    off;
            int unsigned    ib;
            int unsigned    nways;
            int unsigned    base;
            int unsigned    w;
            int unsigned    pick;
            logic [2:0]     ref_age;
            logic [TAG_W-1:0] tag;
            bit             found;
            t_lookup_result r;

            r.outcome = OUT_IGNORE;
            r.way     = '0;
            if (kind == REQ_READ || kind == REQ_WRITE) begin
                off   = eff_offset();
                ib    = eff_index();
                nways = eff_ways();
                base  = ((addr >> off) & ((32'd1 << ib) - 32'd1)) * MAX_WAYS;
                tag   = TAG_W'(addr >> (off + ib));
                found = 1'b0;
                pick  = 0;
                for (w = 0; w < nways; w++) begin
                    if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
                        found = 1'b1;
                        pick  = w;
                    end
                end
                if (found) begin
                    hit_count++;
                    r.outcome = OUT_HIT;
                end else begin
                    // lowest way among the oldest
                    for (w = 1; w < nways; w++) begin
                        if (line_age[base + w] > line_age[base + pick])
                            pick = w;
                    end
                    if (line_valid[base + pick]) begin
                        evict_count++;
                        r.outcome = OUT_EVICT;
                    end else begin
                        r.outcome = OUT_FILL;
                    end
                    line_valid[base + pick] = 1'b1;
                    line_tag[base + pick]   = tag;
                    miss_count++;
                end
                ref_age = line_age[base + pick];
                for (w = 0; w < nways; w++) begin
                    if (w != pick && line_age[base + w] < ref_age)
                        line_age[base + w] = line_age[base + w] + 3'd1;
                end
                line_age[base + pick] = 3'd0;
                r.way = 3'(pick);
            end
            r.hit_total   = hit_count;
            r.miss_total  = miss_count;
            r.evict_total = evict_count;
            expected_results.push_back(r);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(logic [1:0] outcome, logic [2:0] way,
                                   logic [31:0] hit_total, logic [31:0] miss_total,
                                   logic [31:0] evict_total);
            t_lookup_result want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual outcome %0d way %0d",
                         $time, outcome, way);
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            compare_field("outcome", 32'(want.outcome), 32'(outcome));
            compare_field("way_used", 32'(want.way), 32'(way));
            compare_field("hit_total", want.hit_total, hit_total);
            compare_field("miss_total", want.miss_total, miss_total);
            compare_field("evict_total", want.evict_total, evict_total);
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
// bench top for set_assoc_cache_lru_lookup_unit: directed and random traffic,
// random idling on both channels, checked against tag_store_tracker
// depends on sacl_pkg, lru_tag_tracker_pkg and the unit under test
`timescale 1ns / 1ps

module tb_top;

    import sacl_pkg::*;
    import lru_tag_tracker_pkg::*;

    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 70;
    localparam int SET_POOL      = 2;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 60;
    localparam int DRAIN_EXTRA   = 4;
    localparam int STALL_LIMIT   = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [3:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [31:0] i_address;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_outcome;
    logic [2:0]  o_way_used;
    logic [31:0] o_hit_total;
    logic [31:0] o_miss_total;
    logic [31:0] o_evict_total;

    tag_store_tracker board = new();
    bit steady = 1'b0;
    int settings_seen = 0;

    set_assoc_cache_lru_lookup_unit #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_address     (i_address),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_outcome     (o_outcome),
        .o_way_used    (o_way_used),
        .o_hit_total   (o_hit_total),
        .o_miss_total  (o_miss_total),
        .o_evict_total (o_evict_total)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // valid stays high across back-to-back transactions in steady phases, else a random idle gap comes first
    task automatic send_request(input logic [1:0] kind, input logic [31:0] addr);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_address  <= addr;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(kind, addr);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_EXTRA) @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [2:0] off, input logic [3:0] ib,
                                 input logic [3:0] ways);
        logic [3:0] spare;
        spare = 4'($urandom);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_OFFSET;
        i_cfg_data <= {1'b0, off};
        @(posedge i_clk);
        board.write_reg(CFG_OFFSET, {1'b0, off});
        i_cfg_idx  <= CFG_INDEX;
        i_cfg_data <= ib;
        @(posedge i_clk);
        board.write_reg(CFG_INDEX, ib);
        i_cfg_idx  <= CFG_WAYS;
        i_cfg_data <= ways;
        @(posedge i_clk);
        board.write_reg(CFG_WAYS, ways);
        // unmapped index, no effect expected
        i_cfg_idx  <= CFG_SPARE;
        i_cfg_data <= spare;
        @(posedge i_clk);
        board.write_reg(CFG_SPARE, spare);
        i_cfg_we <= 1'b0;
        settings_seen++;
    endtask

    initial begin : result_sink
        int gap;
        int hold_left;
        int seen;
        gap       = 0;
        hold_left = 0;
        seen      = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                board.check_result(o_outcome, o_way_used, o_hit_total, o_miss_total,
                                   o_evict_total);
                seen++;
                gap = steady ? 0 : $urandom_range(0, 13);
                if (seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        int          phase;
        int          counted;
        int          pick;
        int          i;
        int unsigned off;
        int unsigned ib;
        int unsigned nways;
        logic [31:0] addr;
        logic [31:0] set_pool [SET_POOL];
        logic [31:0] tag_pool [MAX_WAYS + 2];

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_OFFSET;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_req_type <= REQ_READ;
        i_address  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, one way: fill, hit, ignored types, eviction
        send_request(REQ_READ, 32'h0000_0000);
        send_request(REQ_WRITE, 32'h0000_000F);
        send_request(REQ_FETCH, 32'h0000_0000);
        send_request(REQ_SPARE, 32'hFFFF_FFFF);
        send_request(REQ_READ, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 32'h0001_0000);
        send_request(REQ_READ, 32'h0000_0000);
        drain_results();

        // largest block, eight ways: fill one set, then evict the oldest
        apply_setting(3'd7, 4'd3, 4'd8);
        for (i = 0; i < 9; i++)
            send_request(i[0] ? REQ_WRITE : REQ_READ, 32'(i) << 10);
        send_request(REQ_READ, 32'h0000_0800);
        send_request(REQ_WRITE, 32'hFFFF_FC00);
        drain_results();

        // offset below minimum, index and ways beyond their maximum
        apply_setting(3'd0, 4'd15, 4'd12);
        send_request(REQ_READ, 32'hFFFF_FFF0);
        send_request(REQ_WRITE, 32'h8000_0000);
        drain_results();

        // fewer ways on old lines leaves the ages out of order
        apply_setting(3'd4, 4'd0, 4'd3);
        send_request(REQ_READ, 32'h0000_0400);
        send_request(REQ_WRITE, 32'h0000_0000);
        send_request(REQ_READ, 32'h1234_5670);
        drain_results();

        // zero ways acts as one
        apply_setting(3'd5, 4'd1, 4'd0);
        send_request(REQ_WRITE, 32'h0000_0020);

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: apply_setting(3'd4, 4'd0, 4'd8);
                1: apply_setting(3'd7, 4'd12, 4'd2);
                2: apply_setting(3'd6, 4'd12, 4'd8);
                default: apply_setting(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                                       4'($urandom_range(0, 15)));
            endcase
            steady = (phase % 3 == 1);
            off    = board.eff_offset();
            ib     = board.eff_index();
            nways  = board.eff_ways();
            for (i = 0; i < SET_POOL; i++)
                set_pool[i] = $urandom;
            for (i = 0; i < MAX_WAYS + 2; i++)
                tag_pool[i] = $urandom;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    send_request($urandom_range(0, 1) ? REQ_FETCH : REQ_SPARE, $urandom);
                end else begin
                    if (pick < 25)
                        addr = $urandom;
                    else
                        addr = (tag_pool[$urandom_range(0, nways + 1)] << (off + ib))
                             | ((set_pool[$urandom_range(0, SET_POOL - 1)]
                                 & ((32'd1 << ib) - 32'd1)) << off)
                             | ($urandom & ((32'd1 << off) - 32'd1));
                    send_request($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, addr);
                    counted++;
                end
            end
        end
        steady = 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("checked %0d lookups over %0d register settings", board.checked,
                 settings_seen + 1);
        $display("totals seen: %0d hits, %0d misses, %0d evictions", board.hit_count,
                 board.miss_count, board.evict_count);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/sacl_pkg.sv
hdl/sacl_ctrl.sv
hdl/sacl_datapath.sv
hdl/set_assoc_cache_lru_lookup_unit.sv
hdl/sacl_checker.sv
bench/lru_tag_tracker_pkg.sv
bench/tb_top.sv
